// ----- hw/rtl/npc_pkg.sv -----
// shared types, constants and helpers for the nearest palette color unit
`default_nettype none

package npc_pkg;

    // palette geometry
    localparam int PALETTE_SIZE = 16;
    localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

    // field widths
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 4;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = 18;

    // largest distance three channels can produce
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * ((1 << CHAN_W) - 1) * ((1 << CHAN_W) - 1));

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // one request as it travels down the chain, with its running best match
    typedef struct packed {
        logic                req_type;
        logic [COLOR_W-1:0]  entry_index;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [COLOR_W-1:0]  best_index;
        logic [DIST_W-1:0]   best_dist;
    } npc_item_t;

    // low bits of a cell number as a color index, zero filled when narrower
    function automatic logic [COLOR_W-1:0] to_color_index(input logic [IDX_W-1:0] id);
        logic [IDX_W+COLOR_W-1:0] ext;
        ext = {{COLOR_W{1'b0}}, id};
        return ext[COLOR_W-1:0];
    endfunction

    // true when a write index addresses this cell
    function automatic logic index_match(input logic [IDX_W-1:0]   id,
                                         input logic [COLOR_W-1:0] idx);
        logic [IDX_W+COLOR_W-1:0] a;
        logic [IDX_W+COLOR_W-1:0] b;
        a = {{COLOR_W{1'b0}}, id};
        b = {{IDX_W{1'b0}}, idx};
        return a == b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/npc_cell.sv -----
// one palette entry with its distance and compare stage
`default_nettype none

module npc_cell
    import npc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [IDX_W-1:0] cell_id,
    input  wire logic             in_valid,
    input  wire npc_item_t        in_item,
    output logic                  out_valid,
    output npc_item_t             out_item
);

    logic [3*CHAN_W-1:0] entry_reg;
    logic                valid_reg;
    npc_item_t           item_reg;
    npc_item_t           item_next;

    logic [CHAN_W-1:0]   diff_r;
    logic [CHAN_W-1:0]   diff_g;
    logic [CHAN_W-1:0]   diff_b;
    logic [SQ_W-1:0]     sq_r;
    logic [SQ_W-1:0]     sq_g;
    logic [SQ_W-1:0]     sq_b;
    logic [DIST_W-1:0]   dist_sq;
    logic                wr_hit;

    // absolute channel differences against the stored entry
    always_comb
    begin
        diff_r = (in_item.red >= entry_reg[3*CHAN_W-1:2*CHAN_W])
               ? in_item.red - entry_reg[3*CHAN_W-1:2*CHAN_W]
               : entry_reg[3*CHAN_W-1:2*CHAN_W] - in_item.red;
        diff_g = (in_item.green >= entry_reg[2*CHAN_W-1:CHAN_W])
               ? in_item.green - entry_reg[2*CHAN_W-1:CHAN_W]
               : entry_reg[2*CHAN_W-1:CHAN_W] - in_item.green;
        diff_b = (in_item.blue >= entry_reg[CHAN_W-1:0])
               ? in_item.blue - entry_reg[CHAN_W-1:0]
               : entry_reg[CHAN_W-1:0] - in_item.blue;
    end

    // squared distance
    always_comb
    begin
        sq_r    = diff_r * diff_r;
        sq_g    = diff_g * diff_g;
        sq_b    = diff_b * diff_b;
        dist_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    end

    // keep the earlier winner unless this entry is strictly closer
    always_comb
    begin
        item_next = in_item;
        if (in_item.req_type == REQ_PIXEL && dist_sq < in_item.best_dist)
        begin
            item_next.best_index = to_color_index(cell_id);
            item_next.best_dist  = dist_sq;
        end
    end

    assign wr_hit = in_valid && in_item.req_type == REQ_WRITE
                  && index_match(cell_id, in_item.entry_index);

    // palette entry, written as a write request passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (advance && wr_hit)
        begin
            entry_reg <= {in_item.red, in_item.green, in_item.blue};
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_palette_color_unit.sv -----
// Nearest palette color unit: maps an RGB pixel to the closest of the palette
// entries by squared Euclidean distance, lowest index winning a tie. Palette
// writes and pixels share one request stream and run down a row of cells,
// one cell per palette entry, so a write affects exactly the pixels sent
// after it. One request is taken per clock unless the output stalls. The
// chain moves as one: while a result sits unclaimed in the output register,
// no stage advances and no request is taken. Palette writes give no result
// and entries reset to black.
`default_nettype none

module nearest_palette_color_unit
    import npc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // entry_index[3:0], red[11:4], green[19:12], blue[27:20]
    input  wire logic [0:0]  s_tuser,  // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // color_index[3:0], best_distance_sq[21:4]
);

    logic                     advance;
    logic [PALETTE_SIZE:0]    stage_valid;
    npc_item_t                stage_item [PALETTE_SIZE+1];

    logic                     m_valid_reg;
    logic [COLOR_W-1:0]       m_index_reg;
    logic [DIST_W-1:0]        m_dist_reg;
    logic                     last_pixel;

    // whole chain moves when the output register is free or being drained
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    // unpack the request; best distance starts above any real distance
    assign stage_valid[0] = s_tvalid;
    assign stage_item[0]  = '{req_type:    s_tuser[0],
                              entry_index: s_tdata[3:0],
                              red:         s_tdata[11:4],
                              green:       s_tdata[19:12],
                              blue:        s_tdata[27:20],
                              best_index:  '0,
                              best_dist:   '1};

    // one cell per palette entry
    for (genvar g = 0; g < PALETTE_SIZE; g++)
    begin : g_cell
        npc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cell_id   (IDX_W'(g)),
            .in_valid  (stage_valid[g]),
            .in_item   (stage_item[g]),
            .out_valid (stage_valid[g+1]),
            .out_item  (stage_item[g+1])
        );
    end

    assign last_pixel = stage_valid[PALETTE_SIZE]
                      && stage_item[PALETTE_SIZE].req_type == REQ_PIXEL;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= last_pixel;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_index_reg <= stage_item[PALETTE_SIZE].best_index;
            m_dist_reg  <= stage_item[PALETTE_SIZE].best_dist;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_dist_reg, m_index_reg};

`ifndef SYNTHESIS
    // every pixel leaving the chain has been matched against some entry
    a_last_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        last_pixel |-> stage_item[PALETTE_SIZE].best_dist <= MAX_DIST)
        else $error("pixel left the chain without a real distance");

    // reported distance never exceeds what three channels can give
    a_out_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_dist_reg <= MAX_DIST)
        else $error("result distance out of range");

    // a held result freezes every stage of the chain
    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stage_valid[PALETTE_SIZE:1]))
        else $error("chain moved while the output was stalled");

    // a new result comes only from a pixel at the end of the chain
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(last_pixel && advance))
        else $error("result appeared without a pixel behind it");
`endif

endmodule

`default_nettype wire

// ----- bench/nearest_palette_color_checker.sv -----
// checker for the nearest palette color unit: mirrors the palette and scores every result
module nearest_palette_color_checker
    import npc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index[3:0], red[11:4], green[19:12], blue[27:20]
    input  logic [0:0]  s_tuser,   // req_type[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // color_index[3:0], best_distance_sq[21:4]
    output int          mismatch_count,
    output int          pending_results,
    output int          pixels_checked,
    output int          palette_writes
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_color_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_index;
        logic [DIST_W-1:0]  distance_sq;
    } nearest_match_t;

    rgb_color_t     palette_copy [PALETTE_SIZE];
    nearest_match_t expected_matches [$];

    // scan from entry 0 upward, replace only on a strictly smaller distance
    function automatic nearest_match_t find_nearest_entry(input logic [CHAN_W-1:0] r,
                                                          input logic [CHAN_W-1:0] g,
                                                          input logic [CHAN_W-1:0] b);
        nearest_match_t best;
        int best_dist;
        int best_id;
        int dr;
        int dg;
        int db;
        int cand_dist;
        best_dist = 32'h7fff_ffff;
        best_id   = 0;
        for (int e = 0; e < PALETTE_SIZE; e++)
        begin
            dr        = int'(r) - int'(palette_copy[e].red);
            dg        = int'(g) - int'(palette_copy[e].green);
            db        = int'(b) - int'(palette_copy[e].blue);
            cand_dist = dr * dr + dg * dg + db * db;
            if (cand_dist < best_dist)
            begin
                best_dist = cand_dist;
                best_id   = e;
            end
        end
        best.color_index = COLOR_W'(best_id);
        best.distance_sq = DIST_W'(best_dist);
        return best;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // watch both channels, predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin : monitor
        nearest_match_t     want;
        nearest_match_t     predicted;
        logic [COLOR_W-1:0] got_index;
        logic [DIST_W-1:0]  got_dist;
        if (!rst_n)
        begin
            for (int e = 0; e < PALETTE_SIZE; e++)
                palette_copy[e] = '0;
            expected_matches.delete();
            mismatch_count  = 0;
            pending_results = 0;
            pixels_checked  = 0;
            palette_writes  = 0;
        end
        else
        begin
            // accepted request: palette write or pixel lookup
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == REQ_WRITE)
                begin
                    if (int'(s_tdata[3:0]) < PALETTE_SIZE)
                        palette_copy[s_tdata[3:0]] = '{red:   s_tdata[11:4],
                                                       green: s_tdata[19:12],
                                                       blue:  s_tdata[27:20]};
                    palette_writes++;
                end
                else
                begin
                    predicted = find_nearest_entry(s_tdata[11:4], s_tdata[19:12],
                                                   s_tdata[27:20]);
                    expected_matches = {expected_matches, predicted};
                end
            end

            // accepted result against the oldest pending lookup
            if (m_tvalid && m_tready)
            begin
                got_index = m_tdata[3:0];
                got_dist  = m_tdata[21:4];
                if (expected_matches.size() == 0)
                    report_mismatch($sformatf(
                        "result index %0d distance %0d with no pixel pending",
                        got_index, got_dist));
                else
                begin
                    want = expected_matches.pop_front();
                    if (got_index !== want.color_index)
                        report_mismatch($sformatf("color_index got %0d expected %0d",
                                                  got_index, want.color_index));
                    if (got_dist !== want.distance_sq)
                        report_mismatch($sformatf("best_distance_sq got %0d expected %0d",
                                                  got_dist, want.distance_sq));
                    pixels_checked++;
                end
            end

            pending_results = expected_matches.size();
        end
    end

endmodule

// ----- bench/nearest_palette_color_unit_tb.sv -----
// testbench top for the nearest palette color unit: stimulus, traffic shaping and verdict
module nearest_palette_color_unit_tb;
    import npc_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } traffic_phase_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // entry_index[3:0], red[11:4], green[19:12], blue[27:20]
    logic [0:0]  s_tuser;   // req_type[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // color_index[3:0], best_distance_sq[21:4]

    traffic_phase_t phase;
    int             send_idle_pct;
    int             recv_stall_pct;
    logic           hold_done;
    int             cycle_count;
    int             mismatch_count;
    int             pending_results;
    int             pixels_checked;
    int             palette_writes;

    // colors last written per entry, used to aim pixels at or near the palette
    logic [23:0] written_color [PALETTE_SIZE];

    nearest_palette_color_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nearest_palette_color_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .pixels_checked  (pixels_checked),
        .palette_writes  (palette_writes)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles", $time, cycle_count);
        $display("nearest_palette_color_unit verification failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off in the backpressure phase
    initial
    begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_BACKPRESSURE && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one request, with random idle cycles ahead of it, and wait for its acceptance
    task automatic send_item(input logic              req,
                             input logic [COLOR_W-1:0] idx,
                             input logic [CHAN_W-1:0]  r,
                             input logic [CHAN_W-1:0]  g,
                             input logic [CHAN_W-1:0]  b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0000, b, g, r, idx};
        if (req == REQ_WRITE)
            written_color[idx] = {b, g, r};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // small random offset around a channel value, saturated to the channel range
    function automatic logic [CHAN_W-1:0] nudge_channel(input logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CHAN_W'(v);
    endfunction

    // reset, directed requests, then random traffic phase by phase
    initial
    begin : stimulus
        int                 pick;
        logic [COLOR_W-1:0] idx;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        logic [23:0]        base;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_WRITE;
        phase          = PH_STEADY;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int e = 0; e < PALETTE_SIZE; e++)
            written_color[e] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lookups before any write: black entry 0 wins, largest and zero distance
        send_item(REQ_PIXEL, 4'hF, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_PIXEL, 4'h0, 8'h00, 8'h00, 8'h00);
        // white at the top entry, then mid-gray on either side of the midpoint
        send_item(REQ_WRITE, 4'hF, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_PIXEL, 4'h0, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_PIXEL, 4'h5, 8'h80, 8'h80, 8'h80);
        send_item(REQ_PIXEL, 4'hA, 8'h7F, 8'h7F, 8'h7F);
        // tie between the black entries and two primaries: entry 0 wins
        send_item(REQ_WRITE, 4'h3, 8'd100, 8'd0, 8'd0);
        send_item(REQ_WRITE, 4'h7, 8'd0, 8'd100, 8'd0);
        send_item(REQ_PIXEL, 4'h0, 8'd50, 8'd50, 8'd0);
        // move entry 0 away: the tie now goes to entry 1
        send_item(REQ_WRITE, 4'h0, 8'hFF, 8'h00, 8'h00);
        send_item(REQ_PIXEL, 4'h0, 8'd50, 8'd50, 8'd0);
        // duplicate entries with an exact hit: the lower one wins
        send_item(REQ_WRITE, 4'h9, 8'd10, 8'd20, 8'd30);
        send_item(REQ_WRITE, 4'h5, 8'd10, 8'd20, 8'd30);
        send_item(REQ_PIXEL, 4'hF, 8'd10, 8'd20, 8'd30);
        // single channel extremes
        send_item(REQ_PIXEL, 4'h0, 8'h00, 8'h00, 8'hFF);
        send_item(REQ_PIXEL, 4'h0, 8'h00, 8'hFF, 8'h00);
        send_item(REQ_WRITE, 4'hC, 8'h00, 8'h00, 8'hFF);
        send_item(REQ_PIXEL, 4'h0, 8'h01, 8'h00, 8'hFE);
        send_item(REQ_PIXEL, 4'h0, 8'hFF, 8'h00, 8'hFF);

        // random traffic: a mix of palette writes and lookups aimed at the palette
        for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++)
        begin
            phase = traffic_phase_t'(p);
            case (phase)
                PH_SENDER_IDLE:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                PH_RECEIVER_STALL:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                PH_BOTH_IDLE:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            repeat (ITEMS_PER_PHASE)
            begin
                idx  = COLOR_W'($urandom_range(15));
                base = written_color[IDX_W'($urandom_range(PALETTE_SIZE - 1))];
                pick = $urandom_range(9);
                if ($urandom_range(99) < 20)
                begin
                    // palette write: random, copy of another entry, or corner color
                    if (pick < 5)
                        {b, g, r} = 24'($urandom);
                    else if (pick < 7)
                        {b, g, r} = base;
                    else
                    begin
                        r = {CHAN_W{$urandom_range(1) == 1}};
                        g = {CHAN_W{$urandom_range(1) == 1}};
                        b = {CHAN_W{$urandom_range(1) == 1}};
                    end
                    send_item(REQ_WRITE, idx, r, g, b);
                end
                else
                begin
                    // lookup: random, exact palette color, near a palette color, or corner
                    if (pick < 4)
                        {b, g, r} = 24'($urandom);
                    else if (pick < 7)
                        {b, g, r} = base;
                    else if (pick < 9)
                    begin
                        r = nudge_channel(base[7:0]);
                        g = nudge_channel(base[15:8]);
                        b = nudge_channel(base[23:16]);
                    end
                    else
                    begin
                        r = {CHAN_W{$urandom_range(1) == 1}};
                        g = {CHAN_W{$urandom_range(1) == 1}};
                        b = {CHAN_W{$urandom_range(1) == 1}};
                    end
                    send_item(REQ_PIXEL, idx, r, g, b);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain: every lookup answered, then a margin past the pipeline depth
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d palette writes and %0d checked lookups, %0d mismatches",
                 palette_writes, pixels_checked, mismatch_count);
        $display("traffic: steady, sender idle, receiver stall, mixed, %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0)
            $display("nearest_palette_color_unit verification clean");
        else
            $display("nearest_palette_color_unit verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/npc_pkg.sv
hw/rtl/npc_cell.sv
hw/rtl/nearest_palette_color_unit.sv
bench/nearest_palette_color_checker.sv
bench/nearest_palette_color_unit_tb.sv
